// File: rtl/lfu_cache_replacement_assert.svh
// Assertion macros used by the cache top level.
`ifndef LFU_CACHE_REPLACEMENT_ASSERT_SVH
`define LFU_CACHE_REPLACEMENT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define LFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/lfc_pkg.sv
// Package with shared constants and types of the LFU cache.
`timescale 1ns / 1ps
package lfc_pkg;
    localparam int unsigned DefaultEntries = 16;
    localparam int unsigned CapWidth = 5;
    localparam logic [31:0] MissValue = 32'hFFFF_FFFF;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
    localparam logic OpGet = 1'b0;
    localparam logic OpPut = 1'b1;
    localparam logic [1:0] AddrCapacity = 2'd0;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic        touch;    // hit entry: bump count, stamp
        logic        wr_value; // hit entry: overwrite value
        logic        evict;    // invalidate the chosen victim
        logic        insert;   // fill the chosen free entry
        logic [31:0] key;
        logic [31:0] value;
        logic [63:0] stamp;
    } cell_cmd_t;

    // Data passed from one cell to the next along the chain.
    typedef struct packed {
        logic        hit;
        logic [31:0] hit_value;
        logic        any_free;
        logic        vic_ok;
        logic [31:0] vic_count;
        logic [63:0] vic_stamp;
    } chain_t;
endpackage

// File: rtl/lfc_cell.sv
// One cache entry with its compare and its registered stage of the reduction chain.
`timescale 1ns / 1ps
module lfc_cell
    import lfc_pkg::*;
#(
    parameter int unsigned IDX_W = $clog2(DefaultEntries),
    parameter int unsigned INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] evict_idx,
    input  logic [IDX_W-1:0] insert_idx,
    input  chain_t           chain_in,
    input  logic [IDX_W-1:0] vic_idx_in,
    input  logic [IDX_W-1:0] free_idx_in,
    output chain_t           chain_out,
    output logic [IDX_W-1:0] vic_idx_out,
    output logic [IDX_W-1:0] free_idx_out
);
    logic             valid_reg, valid_next;
    logic [31:0]      key_reg, value_reg, count_reg;
    logic [63:0]      stamp_reg;
    chain_t           chain_reg, chain_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             match, better, evict_en, insert_en;

    assign match  = valid_reg && (key_reg == cmd.key);
    // This entry beats every victim candidate to its left; ties keep the left one.
    assign better = valid_reg && (!chain_in.vic_ok || (count_reg < chain_in.vic_count) ||
                    ((count_reg == chain_in.vic_count) && (stamp_reg < chain_in.vic_stamp)));
    assign evict_en  = cmd.evict && (evict_idx == IDX_W'(INDEX));
    assign insert_en = cmd.insert && (insert_idx == IDX_W'(INDEX));

    // Chain stage: hit and first free slot pass through, victim takes the better one.
    always_comb
    begin
        chain_next    = chain_in;
        vic_idx_next  = vic_idx_in;
        free_idx_next = free_idx_in;
        if (match)
        begin
            chain_next.hit       = 1'b1;
            chain_next.hit_value = value_reg;
        end
        if (!valid_reg && !chain_in.any_free)
        begin
            chain_next.any_free = 1'b1;
            free_idx_next       = IDX_W'(INDEX);
        end
        if (better)
        begin
            chain_next.vic_ok    = 1'b1;
            chain_next.vic_count = count_reg;
            chain_next.vic_stamp = stamp_reg;
            vic_idx_next         = IDX_W'(INDEX);
        end
    end

    // Valid bit follows evictions and inserts; an insert into the evicted slot wins.
    always_comb
    begin
        valid_next = valid_reg;
        if (evict_en)
            valid_next = 1'b0;
        if (insert_en)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            chain_reg    <= '0;
            vic_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            chain_reg    <= chain_next;
            vic_idx_reg  <= vic_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    // Payload of the entry.
    always_ff @(posedge clk)
    begin
        if (insert_en)
        begin
            key_reg   <= cmd.key;
            value_reg <= cmd.value;
            count_reg <= 32'd1;
            stamp_reg <= cmd.stamp;
        end
        else if (cmd.touch && match)
        begin
            if (cmd.wr_value)
                value_reg <= cmd.value;
            if (count_reg != CountMax)
                count_reg <= count_reg + 32'd1;
            stamp_reg <= cmd.stamp;
        end
    end

    assign chain_out    = chain_reg;
    assign vic_idx_out  = vic_idx_reg;
    assign free_idx_out = free_idx_reg;
endmodule

// File: rtl/lfu_cache_replacement.sv
// Top level of the LFU cache: controller, register port and cell chain.
//
// Usage. Configure capacity_in_use (address 0) over the APB-style port while
// idle. Issue an item by raising start with op, key and value while busy is
// low; the item is taken at that edge and busy stays high while the compare
// and victim search ripple through the registered cell chain, one cell per
// cycle, and then while the touch, eviction and insert are written into the
// cells (state StScan, then state StWrite).
// A get (op 0) returns one result: out_valid is high for exactly one cycle,
// the first cycle in which busy is low again, with hit and read_value; a
// miss gives hit 0 and read_value -1. A put gives no result. A new item is
// taken only while busy is low, so each item is finished before the next is
// taken; the time per item is set by the length of the cell chain.
// The receiver cannot stall: each result lasts one cycle.
// Reset clears all valid bits, the access clock, occupancy and sets the
// capacity to 16; stored keys and values need no clearing.
`timescale 1ns / 1ps
`include "lfu_cache_replacement_assert.svh"
module lfu_cache_replacement
    import lfc_pkg::*;
#(
    parameter int unsigned ENTRIES = DefaultEntries
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic [31:0]          key,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    output logic                 hit,
    output logic signed [31:0]   read_value
);
    localparam int unsigned OccW = $clog2(ENTRIES + 1);
    localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StScan  = 2'd1;
    localparam logic [1:0] StWrite = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [IdxW-1:0]     cnt_reg, cnt_next;
    logic [CapWidth-1:0] cap_reg;
    logic [OccW-1:0]     occ_reg, occ_next;
    logic [63:0]         clock_reg;
    logic                op_reg;
    logic [31:0]         key_reg, value_reg;
    logic                out_valid_reg, hit_reg;
    logic [31:0]         read_value_reg;
    logic [OccW-1:0]     cap_eff;
    cell_cmd_t           cmd;
    chain_t              chain [ENTRIES+1];
    logic [IdxW-1:0]     vic_idx [ENTRIES+1];
    logic [IdxW-1:0]     free_idx [ENTRIES+1];
    chain_t              chain_end;
    logic [IdxW-1:0]     vic_end, free_end, insert_idx;
    logic                wr_cfg, in_write, put_live, need_evict;

    // Register port.
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CapWidth'(16);
        else if (wr_cfg && (paddr == AddrCapacity))
            cap_reg <= pwdata[CapWidth-1:0];
    end
    assign prdata = (paddr == AddrCapacity) ? {{(32-CapWidth){1'b0}}, cap_reg} : 32'd0;

    assign cap_eff = (32'(cap_reg) > ENTRIES) ? OccW'(ENTRIES) : OccW'(cap_reg);

    // Cell row: chain of identical entries, one registered stage each.
    assign chain[0]    = '0;
    assign vic_idx[0]  = '0;
    assign free_idx[0] = '0;
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lfc_cell #(
            .IDX_W (IdxW),
            .INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .evict_idx    (vic_end),
            .insert_idx   (insert_idx),
            .chain_in     (chain[i]),
            .vic_idx_in   (vic_idx[i]),
            .free_idx_in  (free_idx[i]),
            .chain_out    (chain[i+1]),
            .vic_idx_out  (vic_idx[i+1]),
            .free_idx_out (free_idx[i+1])
        );
    end

    assign chain_end = chain[ENTRIES];
    assign vic_end   = vic_idx[ENTRIES];
    assign free_end  = free_idx[ENTRIES];

    // Decisions of the write cycle, taken from the end of the chain.
    assign in_write   = (state_reg == StWrite);
    assign put_live   = in_write && (op_reg == OpPut) && (cap_eff != '0);
    assign need_evict = put_live && !chain_end.hit && (occ_reg >= cap_eff) &&
                        chain_end.vic_ok;

    // The new key goes to the lowest free slot once the victim is gone.
    always_comb
    begin
        if (need_evict && (!chain_end.any_free || (vic_end < free_end)))
            insert_idx = vic_end;
        else
            insert_idx = free_end;
    end

    // Commands to the cells.
    always_comb
    begin
        cmd          = '0;
        cmd.key      = key_reg;
        cmd.value    = value_reg;
        cmd.stamp    = clock_reg;
        cmd.touch    = in_write && chain_end.hit &&
                       ((op_reg == OpGet) || (cap_eff != '0));
        cmd.wr_value = (op_reg == OpPut);
        cmd.evict    = need_evict;
        cmd.insert   = put_live && !chain_end.hit && (need_evict || chain_end.any_free);
    end

    // Controller: wait in the scan state while the chain settles, then write.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        occ_next   = occ_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (start)
                begin
                    state_next = StScan;
                    cnt_next   = '0;
                end
            end
            StScan:
            begin
                if (cnt_reg == IdxW'(ENTRIES - 1))
                    state_next = StWrite;
                else
                    cnt_next = cnt_reg + IdxW'(1);
            end
            StWrite:
            begin
                state_next = StIdle;
                if (cmd.evict && !cmd.insert)
                    occ_next = occ_reg - OccW'(1);
                else if (cmd.insert && !cmd.evict)
                    occ_next = occ_reg + OccW'(1);
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= StIdle;
            cnt_reg        <= '0;
            occ_reg        <= '0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            occ_reg       <= occ_next;
            out_valid_reg <= in_write && (op_reg == OpGet);
            if (in_write)
            begin
                hit_reg        <= chain_end.hit;
                read_value_reg <= chain_end.hit ? chain_end.hit_value : MissValue;
            end
            if (cmd.touch || cmd.insert)
                clock_reg <= clock_reg + 64'd1;
        end
    end

    // Item capture at the accepting edge.
    always_ff @(posedge clk)
    begin
        if ((state_reg == StIdle) && start)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    assign busy       = (state_reg != StIdle);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    `LFC_ASSERT_IMP(a_occ_range, clk, rst_n, 1'b1, occ_reg <= OccW'(ENTRIES), "occupancy overflow")
    `LFC_ASSERT_NEXT(a_busy_start, clk, rst_n, start && !busy, busy, "item not taken")
    `LFC_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")
    `LFC_ASSERT_IMP(a_miss_value, clk, rst_n, out_valid && !hit, read_value == MissValue, "miss value wrong")
endmodule
